// ===== rtl/ncs_pkg.sv =====
// shared widths, defaults and codes for the nearest center search block
`default_nettype none

package ncs_pkg;

   // default table geometry
   localparam int MAX_CENTERS_DEF = 16;
   localparam int MAX_DIM_DEF     = 128;

   // field widths
   localparam int VAL_W     = 16;
   localparam int ACC_W     = 40;
   localparam int CIDX_W    = 4;
   localparam int EIDX_W    = 7;
   localparam int NCTR_W    = 5;
   localparam int CSR_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int OPND_W    = VAL_W + 1;
   localparam int PROD_W    = 2 * OPND_W;

   // reset value of the center count register
   localparam logic [NCTR_W-1:0] NCTR_RESET = NCTR_W'(16);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_MODE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CENTERS_IN_USE = CSR_IDX_W'(1);

   // request function codes
   localparam logic FUNC_CENTER_WRITE = 1'b0;
   localparam logic FUNC_QUERY        = 1'b1;

   // score metric codes
   localparam logic METRIC_DOT = 1'b0;
   localparam logic METRIC_L2  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/nearest_center_search_top.sv =====
// Nearest center search: a center table in one memory, per-center scores in a
// second memory, and one shared multiply-accumulate path that walks the centers.
// A center element write (func 0) does not raise busy. A query element (func 1)
// keeps busy high while it walks the n centers in use; a query element with
// element index 0 walks all MAX_CENTERS entries instead and also zeroes every
// other score entry. The score memory port and the one multiplier handle one
// center per cycle. The result of an is_last element shows on rsp_valid for one
// cycle, for a query without index 0 the cycle right after busy falls; it cannot
// be held off. After reset the score memory is cleared one entry per cycle, and
// busy stays high until that clearing sweep ends; configuration writes are taken
// during that time and whenever busy is low.
`default_nettype none

module nearest_center_search_top
   import ncs_pkg::*;
#(
   parameter int MAX_CENTERS = MAX_CENTERS_DEF,
   parameter int MAX_DIM     = MAX_DIM_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic                     req_func,
   input  wire logic [CIDX_W-1:0]        req_center_index,
   input  wire logic [EIDX_W-1:0]        req_element_index,
   input  wire logic signed [VAL_W-1:0]  req_element_value,
   input  wire logic                     req_is_last,
   output      logic                     rsp_valid,
   output      logic [CIDX_W-1:0]        rsp_best_center,
   output      logic signed [ACC_W-1:0]  rsp_best_score,
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_W-1:0]         csr_write_data
);

   localparam int CW     = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int DW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH  = MAX_CENTERS * MAX_DIM;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW     = ((CW > NCTR_W) ? CW : NCTR_W) + 1;
   localparam int ELEM_N = 2 ** EIDX_W;

   typedef struct packed {
      logic [CW-1:0] idx;
      logic          in_use;
      logic          final_ctr;
      logic          last;
      logic          clr;
   } stage_type;

   // configuration registers
   logic              metric_ff;
   logic [NCTR_W-1:0] centers_ff;

   // sweep control
   logic            run_ff;
   logic [CW-1:0]   cnt_ff;
   logic [CW-1:0]   lim_ff;
   logic [CW-1:0]   nlast_ff;
   logic [AW-1:0]   base_ff;
   logic            wipe_ff;
   logic            clr_ff;
   logic            last_ff;
   logic signed [VAL_W-1:0] val_ff;

   // pipeline
   logic      v1_ff, v2_ff, v3_ff;
   stage_type st0, st1_ff, st2_ff, st3_ff;

   // memories and their read words
   logic signed [VAL_W-1:0] center_mem [DEPTH];
   logic signed [ACC_W-1:0] acc_mem [MAX_CENTERS];
   logic signed [VAL_W-1:0] ctr_rd_ff;
   logic signed [ACC_W-1:0] acc_rd_ff;

   // datapath
   logic signed [OPND_W-1:0] diff, opa, opb;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] term_ff;
   logic signed [ACC_W-1:0]  base_acc_ff;
   logic signed [ACC_W-1:0]  term_ext;
   logic signed [ACC_W-1:0]  sum_in;
   logic signed [ACC_W-1:0]  sum_ff;
   logic signed [ACC_W-1:0]  best_ff;
   logic [CW-1:0]            best_idx_ff;
   logic                     take;
   logic signed [ACC_W-1:0]  nb_score;
   logic [CW-1:0]            nb_idx;

   // result registers
   logic                    rsp_valid_ff;
   logic [CIDX_W-1:0]       rsp_center_ff;
   logic signed [ACC_W-1:0] rsp_score_ff;

   // request decode
   logic [DW-1:0] mod_tab [ELEM_N];
   logic [DW-1:0] elem_mod;
   logic [NW-1:0] ncfg;
   logic [CW-1:0] nlast_cfg;
   logic          accept, cw_en, q_acc, cidx_ok;
   logic [AW-1:0] wr_addr;

   // element index folded onto the vector length
   for (genvar g = 0; g < ELEM_N; g++) begin : g_mod
      assign mod_tab[g] = DW'(g % MAX_DIM);
   end
   assign elem_mod = mod_tab[req_element_index];

   assign busy    = run_ff | v1_ff | v2_ff | v3_ff;
   assign accept  = start & ~busy;
   assign cidx_ok = 32'(req_center_index) < 32'(MAX_CENTERS);
   assign cw_en   = accept & (req_func == FUNC_CENTER_WRITE) & cidx_ok;
   assign q_acc   = accept & (req_func == FUNC_QUERY);
   assign wr_addr = AW'(32'(req_center_index) * 32'(MAX_DIM)) + AW'(elem_mod);

   // last center in use, count clamped to 1..MAX_CENTERS
   assign ncfg = NW'(centers_ff);
   always_comb begin
      if (ncfg == '0) begin
         nlast_cfg = '0;
      end else if (ncfg >= NW'(MAX_CENTERS)) begin
         nlast_cfg = CW'(MAX_CENTERS - 1);
      end else begin
         nlast_cfg = CW'(ncfg - NW'(1));
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff  <= METRIC_DOT;
         centers_ff <= NCTR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_METRIC_MODE:    metric_ff  <= csr_write_data[0];
            CSR_CENTERS_IN_USE: centers_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // center sweep sequencer, reset starts a clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b1;
         cnt_ff   <= '0;
         base_ff  <= '0;
         lim_ff   <= CW'(MAX_CENTERS - 1);
         nlast_ff <= '0;
         wipe_ff  <= 1'b1;
         clr_ff   <= 1'b1;
         last_ff  <= 1'b0;
      end else if (q_acc) begin
         run_ff   <= 1'b1;
         cnt_ff   <= '0;
         base_ff  <= AW'(elem_mod);
         lim_ff   <= (req_element_index == '0) ? CW'(MAX_CENTERS - 1) : nlast_cfg;
         nlast_ff <= nlast_cfg;
         wipe_ff  <= 1'b0;
         clr_ff   <= (req_element_index == '0);
         last_ff  <= req_is_last;
      end else if (run_ff) begin
         if (cnt_ff == lim_ff) begin
            run_ff <= 1'b0;
         end else begin
            cnt_ff  <= cnt_ff + CW'(1);
            base_ff <= base_ff + AW'(MAX_DIM);
         end
      end
   end

   // query word value
   always_ff @(posedge clock) begin
      if (q_acc) begin
         val_ff <= req_element_value;
      end
   end

   // flags of the center being issued
   always_comb begin
      st0.idx       = cnt_ff;
      st0.in_use    = ~wipe_ff & (cnt_ff <= nlast_ff);
      st0.final_ctr = ~wipe_ff & (cnt_ff == nlast_ff);
      st0.last      = last_ff;
      st0.clr       = clr_ff;
   end

   // stage valids and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= run_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff & st3_ff.final_ctr & st3_ff.last;
      end
   end

   // stage flags
   always_ff @(posedge clock) begin
      st1_ff <= st0;
      st2_ff <= st1_ff;
      st3_ff <= st2_ff;
   end

   // center table
   always_ff @(posedge clock) begin
      if (cw_en) begin
         center_mem[wr_addr] <= req_element_value;
      end
      ctr_rd_ff <= center_mem[base_ff];
   end

   // score table, read at issue and written back with the stage-2 sum
   always_ff @(posedge clock) begin
      if (v2_ff) begin
         acc_mem[st2_ff.idx] <= sum_in;
      end
      acc_rd_ff <= acc_mem[cnt_ff];
   end

   // shared multiplier: product or squared difference
   always_comb begin
      diff = $signed({val_ff[VAL_W-1], val_ff}) - $signed({ctr_rd_ff[VAL_W-1], ctr_rd_ff});
      if (metric_ff == METRIC_DOT) begin
         opa = $signed({val_ff[VAL_W-1], val_ff});
         opb = $signed({ctr_rd_ff[VAL_W-1], ctr_rd_ff});
      end else begin
         opa = diff;
         opb = diff;
      end
      prod = opa * opb;
   end

   always_ff @(posedge clock) begin
      term_ff     <= st1_ff.in_use ? prod : '0;
      base_acc_ff <= st1_ff.clr ? '0 : acc_rd_ff;
   end

   // accumulate
   assign term_ext = $signed({{(ACC_W - PROD_W){term_ff[PROD_W-1]}}, term_ff});
   assign sum_in   = (metric_ff == METRIC_DOT) ? (base_acc_ff + term_ext)
                                               : (base_acc_ff - term_ext);

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // running best, lowest index wins ties
   assign take     = (st3_ff.idx == '0) | (sum_ff > best_ff);
   assign nb_score = take ? sum_ff : best_ff;
   assign nb_idx   = take ? st3_ff.idx : best_idx_ff;

   always_ff @(posedge clock) begin
      if (v3_ff & st3_ff.in_use) begin
         best_ff     <= nb_score;
         best_idx_ff <= nb_idx;
      end
      if (v3_ff & st3_ff.final_ctr & st3_ff.last) begin
         rsp_score_ff  <= nb_score;
         rsp_center_ff <= CIDX_W'(nb_idx);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_center = rsp_center_ff;
   assign rsp_best_score  = rsp_score_ff;

endmodule

`default_nettype wire

// ===== rtl/ncs_checker.sv =====
// port-level checks for the nearest center search block and their binding
`default_nettype none

module ncs_checker
   import ncs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_func,
   input wire logic rsp_valid
);

   // reset always begins the score clearing sweep
   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("no clearing sweep after reset");

   // a query word keeps the block busy on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_QUERY) |=> busy)
      else $error("query word did not start a sweep");

   // a center write neither blocks nor answers
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_CENTER_WRITE) |=> (!busy && !rsp_valid))
      else $error("center write caused busy or a result");

   // a result only follows a cycle of work
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding sweep");

   // results never come back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

endmodule

bind nearest_center_search_top ncs_checker u_ncs_checker (.*);

`default_nettype wire

// ===== tb/sv/nearest_center_search_checker.sv =====
// score predictor and result checker for the nearest center search block
`timescale 1ns / 1ps

module nearest_center_search_checker
   import ncs_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    busy,
   input  wire logic                    req_func,
   input  wire logic [CIDX_W-1:0]       req_center_index,
   input  wire logic [EIDX_W-1:0]       req_element_index,
   input  wire logic signed [VAL_W-1:0] req_element_value,
   input  wire logic                    req_is_last,
   input  wire logic                    rsp_valid,
   input  wire logic [CIDX_W-1:0]       rsp_best_center,
   input  wire logic signed [ACC_W-1:0] rsp_best_score,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_W-1:0]        csr_write_data,
   output int                           failures,
   output int                           pending
);

   typedef struct packed {
      logic [CIDX_W-1:0] center;
      logic [ACC_W-1:0]  score;
   } nearest_type;

   // predicted winners, oldest first
   nearest_type nearest_q[$];

   // local copy of the center table, the scores and the two registers
   logic signed [VAL_W-1:0] center_tab [MAX_CENTERS_DEF][MAX_DIM_DEF];
   logic signed [ACC_W-1:0] score_acc  [MAX_CENTERS_DEF];
   logic                    metric;
   logic [NCTR_W-1:0]       nctr;
   int                      fail_count = 0;
   nearest_type             got;

   // zero count searches one center, counts past the table size saturate
   function automatic int centers_searched();
      if (nctr == 0) return 1;
      if (nctr > MAX_CENTERS_DEF) return MAX_CENTERS_DEF;
      return int'(nctr);
   endfunction

   // fold one query element into every searched score (index 0 clears all first), queue a winner on last
   function automatic void score_element(input logic [EIDX_W-1:0]       eidx,
                                         input logic signed [VAL_W-1:0] val,
                                         input logic                    last);
      int                      n;
      longint                  term;
      logic signed [ACC_W-1:0] top_score;
      logic [CIDX_W-1:0]       top_center;
      nearest_type             win;
      if (eidx == 0) begin
         foreach (score_acc[i]) score_acc[i] = '0;
      end
      n = centers_searched();
      for (int c = 0; c < n; c++) begin
         if (metric == METRIC_DOT) begin
            term = longint'(val) * longint'(center_tab[c][eidx]);
            score_acc[c] = score_acc[c] + ACC_W'(term);
         end else begin
            term = longint'(val) - longint'(center_tab[c][eidx]);
            score_acc[c] = score_acc[c] - ACC_W'(term * term);
         end
      end
      if (last) begin
         top_center = '0;
         top_score  = score_acc[0];
         // strict compare keeps the lowest index on ties
         for (int c = 1; c < n; c++) begin
            if (score_acc[c] > top_score) begin
               top_score  = score_acc[c];
               top_center = CIDX_W'(c);
            end
         end
         win.center = top_center;
         win.score  = top_score;
         nearest_q.push_back(win);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         metric = METRIC_DOT;
         nctr   = NCTR_RESET;
         foreach (score_acc[i]) score_acc[i] = '0;
         nearest_q.delete();
      end else begin
         // results belong to words taken on earlier edges, so check first
         if (rsp_valid) begin
            if (nearest_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result center %0d score %0d", $realtime,
                           rsp_best_center, rsp_best_score);
               fail_count++;
            end else begin
               got = nearest_q.pop_front();
               if (rsp_best_center !== got.center || rsp_best_score !== got.score) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch center exp %0d got %0d, score exp %0d got %0d",
                              $realtime, got.center, rsp_best_center,
                              $signed(got.score), rsp_best_score);
                  fail_count++;
               end
            end
         end
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_METRIC_MODE:    metric = csr_write_data[0];
               CSR_CENTERS_IN_USE: nctr   = csr_write_data[NCTR_W-1:0];
               default: ;
            endcase
         end
         // accepted word
         if (start && !busy) begin
            if (req_func == FUNC_CENTER_WRITE)
               center_tab[req_center_index][req_element_index] = req_element_value;
            else
               score_element(req_element_index, req_element_value, req_is_last);
         end
      end
      failures <= fail_count;
      pending  <= nearest_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// stimulus, clock, reset and verdict for the nearest center search block
`timescale 1ns / 1ps

module tb;
   import ncs_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_func = FUNC_CENTER_WRITE;
   logic [CIDX_W-1:0]       req_center_index = '0;
   logic [EIDX_W-1:0]       req_element_index = '0;
   logic signed [VAL_W-1:0] req_element_value = '0;
   logic                    req_is_last = 1'b0;
   logic                    rsp_valid;
   logic [CIDX_W-1:0]       rsp_best_center;
   logic signed [ACC_W-1:0] rsp_best_score;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]        csr_write_data = '0;
   int                      failures;
   int                      pending;

   // columns whose entries are written for every center, safe to query
   bit written_at [MAX_CENTERS_DEF][MAX_DIM_DEF];
   bit col_ready  [MAX_DIM_DEF];
   int ready_idx[$];
   int words_sent = 0;
   int quiet_from = 0;
   bit quiet = 1'b0;

   nearest_center_search_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_center_index  (req_center_index),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_best_center   (rsp_best_center),
      .rsp_best_score    (rsp_best_score),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   nearest_center_search_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_center_index  (req_center_index),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_best_center   (rsp_best_center),
      .rsp_best_score    (rsp_best_score),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .failures          (failures),
      .pending           (pending)
   );

   always #5 clock = ~clock;

   // hang guard
   initial begin
      #5000000;
      $display("nearest_center_search_top verification failed");
      $finish;
   end

   // element values leaning toward the extremes
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         2:       return '0;
         3:       return -16'sd1;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // one word on the request port, with an occasional random gap ahead of it
   task automatic drive_word(input logic                    func,
                             input logic [CIDX_W-1:0]       cidx,
                             input logic [EIDX_W-1:0]       eidx,
                             input logic signed [VAL_W-1:0] val,
                             input logic                    last);
      int gap;
      bit full;
      quiet = (words_sent >= quiet_from) && (words_sent < quiet_from + 150);
      if (!quiet && $urandom_range(0, 99) < 23) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
         start             <= 1'b0;
         req_func          <= 1'($urandom);
         req_center_index  <= CIDX_W'($urandom);
         req_element_index <= EIDX_W'($urandom);
         req_element_value <= VAL_W'($urandom);
         req_is_last       <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_func          <= func;
      req_center_index  <= cidx;
      req_element_index <= eidx;
      req_element_value <= val;
      req_is_last       <= last;
      do @(posedge clock); while (busy !== 1'b0);
      words_sent++;
      if (func == FUNC_CENTER_WRITE) begin
         written_at[cidx][eidx] = 1'b1;
         full = 1'b1;
         for (int c = 0; c < MAX_CENTERS_DEF; c++) full &= written_at[c][eidx];
         if (full && !col_ready[eidx]) begin
            col_ready[eidx] = 1'b1;
            ready_idx.push_back(int'(eidx));
         end
      end
   endtask

   // write one coordinate of every center
   task automatic load_center_column(input logic [EIDX_W-1:0] eidx);
      for (int c = 0; c < MAX_CENTERS_DEF; c++)
         drive_word(FUNC_CENTER_WRITE, CIDX_W'(c), eidx, pick_value(), 1'($urandom));
   endtask

   // query point over written coordinates; clear starts at index 0
   task automatic stream_query(input int len, input bit clear, input bit close);
      logic [EIDX_W-1:0] eidx;
      for (int i = 0; i < len; i++) begin
         if (i == 0 && clear)
            eidx = '0;
         else
            eidx = EIDX_W'(ready_idx[$urandom_range(0, ready_idx.size() - 1)]);
         drive_word(FUNC_QUERY, CIDX_W'($urandom), eidx, pick_value(),
                    close && (i == len - 1));
      end
   endtask

   // hold off until every winner is back and the last element has drained
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (MAX_CENTERS_DEF + 8) @(posedge clock);
   endtask

   // write both registers, upper data bits of the mode write are junk
   task automatic set_search(input logic mode, input logic [NCTR_W-1:0] count);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_METRIC_MODE;
      csr_write_data   <= {(CSR_W-1)'($urandom), mode};
      @(posedge clock);
      csr_index        <= CSR_CENTERS_IN_USE;
      csr_write_data   <= CSR_W'(count);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int                      target;
      int                      r;
      int                      col;
      logic signed [VAL_W-1:0] v;
      logic [NCTR_W-1:0]       count;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // coordinates 0 and 127: center 0 small, 1 and 5 tied at the top, 2 at the bottom
      for (int e = 0; e < 2; e++) begin
         for (int c = 0; c < MAX_CENTERS_DEF; c++) begin
            case (c)
               0:       v = 16'sd100;
               1, 5:    v = 16'sd32767;
               2:       v = -16'sd32768;
               3:       v = '0;
               default: v = pick_value();
            endcase
            drive_word(FUNC_CENTER_WRITE, CIDX_W'(c), (e == 0) ? EIDX_W'(0) : EIDX_W'(127),
                       v, c == 7);
         end
      end

      // dot mode at reset settings: tie, most negative query, all zero scores
      drive_word(FUNC_QUERY, '0, EIDX_W'(0), 16'sd32767, 1'b0);
      drive_word(FUNC_QUERY, '1, EIDX_W'(127), 16'sd32767, 1'b1);
      drive_word(FUNC_QUERY, '0, EIDX_W'(0), -16'sd32768, 1'b0);
      drive_word(FUNC_QUERY, '1, EIDX_W'(127), -16'sd32768, 1'b1);
      drive_word(FUNC_QUERY, '0, EIDX_W'(0), '0, 1'b1);
      // zero count searches one center
      drain_results();
      set_search(METRIC_L2, '0);
      drive_word(FUNC_QUERY, '0, EIDX_W'(0), 16'sd12345, 1'b1);
      // count above the table saturates
      drain_results();
      set_search(METRIC_L2, 5'd31);
      drive_word(FUNC_QUERY, '0, EIDX_W'(0), -16'sd32768, 1'b0);
      drive_word(FUNC_QUERY, '0, EIDX_W'(127), 16'sd32767, 1'b1);
      // one center, no clear: scores carry over and idle centers keep theirs
      drain_results();
      set_search(METRIC_DOT, 5'd1);
      drive_word(FUNC_QUERY, '0, EIDX_W'(127), -16'sd1, 1'b1);
      // long run without clear: the center at the bottom wraps past 2^39
      drain_results();
      set_search(METRIC_L2, 5'd16);
      for (int i = 0; i < 140; i++)
         drive_word(FUNC_QUERY, CIDX_W'($urandom), EIDX_W'(127), 16'sd32767, (i % 35) == 34);

      // a few more coordinates before the random part
      drain_results();
      set_search(1'($urandom), 5'd16);
      for (int k = 0; k < 3; k++) begin
         do col = $urandom_range(1, 126); while (col_ready[col]);
         load_center_column(EIDX_W'(col));
      end

      target     = 1150;
      quiet_from = words_sent + $urandom_range(200, 600);
      while (words_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            if (ready_idx.size() < 40) begin
               do col = $urandom_range(1, 126); while (col_ready[col]);
               load_center_column(EIDX_W'(col));
            end
         end else if (r < 14) begin
            drive_word(FUNC_CENTER_WRITE, CIDX_W'($urandom), EIDX_W'($urandom),
                       pick_value(), 1'($urandom));
         end else if (r < 80) begin
            stream_query(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(1, 6), 1'b1, 1'b1);
         end else if (r < 92) begin
            // broken points: missing clear or missing last
            if ($urandom_range(0, 1) == 0)
               stream_query($urandom_range(1, 8), 1'b0, 1'b1);
            else
               stream_query($urandom_range(1, 8), 1'b1, 1'b0);
         end else begin
            case ($urandom_range(0, 5))
               0:       count = '0;
               1:       count = 5'd1;
               2:       count = 5'd16;
               3:       count = 5'd31;
               default: count = NCTR_W'($urandom_range(0, 31));
            endcase
            drain_results();
            set_search(1'($urandom), count);
         end
      end

      drain_results();
      if (failures == 0 && pending == 0)
         $display("nearest_center_search_top verification clean");
      else
         $display("nearest_center_search_top verification failed");
      $finish;
   end

endmodule
